>>> hw/rtl/ddma_pkg.sv
`timescale 1ns / 1ps
package ddma_pkg;

  localparam int SAMPLE_W  = 14;
  localparam int FRAC_W    = 4;
  localparam int MAX_DELAY = 64;
  localparam int DLY_AW    = 6;
  localparam int MAX_HALF  = 32;
  localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
  localparam int WIN_AW    = 7;
  localparam int IDX_W     = 16;
  localparam int S_W       = 15;
  localparam int D_W       = 16;
  localparam int SUM_W     = 23;
  localparam int OUT_W     = 20;
  localparam int NUM_W     = 27;
  localparam int DCNT_W    = 5;
  localparam int DL_W      = 7;
  localparam int H_W       = 6;
  localparam int W_W       = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 14;

  localparam logic [CFG_IDX_W-1:0] REG_BASELINE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd2;

  localparam logic [DL_W-1:0] DELAY_RESET = 7'd46;
  localparam logic [H_W-1:0]  HALF_RESET  = 6'd27;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIV_LD,
    ST_DIV,
    ST_RD_H,
    ST_EMIT_D,
    ST_EMIT_DIV,
    ST_EMIT_H,
    ST_FL_RD,
    ST_EMIT_FL,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_FIRST,
    RD_H,
    RD_M
  } rd_sel_e;

  typedef enum logic [1:0] {
    SEL_D,
    SEL_DIV,
    SEL_MEM
  } out_sel_e;

  typedef struct packed {
    logic     capture;
    rd_sel_e  rd_sel;
    logic     update;
    logic     div_start;
    logic     emit;
    out_sel_e sel;
    logic     emit_avg;
    logic     emit_fin;
    logic     m_dec;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic h_zero;
    logic k_ge_h;
    logic k_ge_w;
    logic eor;
    logic m_zero;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/ddma_in_if.sv
`timescale 1ns / 1ps
interface ddma_in_if;
  logic                          valid;
  logic                          ready;
  logic [ddma_pkg::SAMPLE_W-1:0] sample;
  logic                          end_of_record;

  modport source (output valid, sample, end_of_record, input ready);
  modport sink (input valid, sample, end_of_record, output ready);
endinterface

>>> hw/rtl/ddma_out_if.sv
`timescale 1ns / 1ps
interface ddma_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ddma_pkg::OUT_W-1:0] filtered;
  logic                              averaged;
  logic                              final_res;

  modport source (output valid, filtered, averaged, final_res, input ready);
  modport sink (input valid, filtered, averaged, final_res, output ready);
endinterface

>>> hw/rtl/delay_difference_moving_average_shaper_unit.sv
`timescale 1ns / 1ps
// channel   dir  payload                              transfer when
// in_ch     in   sample, end_of_record                valid && ready
// out_ch    out  filtered, averaged, final_res        valid && ready
// cfg       in   cfg_idx_i, cfg_wdata_i               cfg_we_i
//
// one sample at a time: after read and update, either no result is due or one
// is formed as a passthrough with h = 0, an edge passthrough from the window
// store, or the window average (27-step bit-serial divide by 2h+1, after a load)
// each result flushed at end of record takes one store read
// reset clears control, sum, index and pointers; the stores need no clearing
// a stalled output holds the sequencer in its emit state
module delay_difference_moving_average_shaper_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ddma_in_if.sink                        in_ch,
  ddma_out_if.source                     out_ch,
  input  logic                           cfg_we_i,
  input  logic [ddma_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ddma_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import ddma_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: walks read, update, divide, emit and flush steps
  ddma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_ready_o (in_ch.ready)
  );

  // datapath: config registers, delay and window stores, running sum,
  // divider and output register
  ddma_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_valid_i  (in_ch.valid),
    .sample_i    (in_ch.sample),
    .eor_i       (in_ch.end_of_record),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .filtered_o  (out_ch.filtered),
    .averaged_o  (out_ch.averaged),
    .final_res_o (out_ch.final_res)
  );
endmodule

>>> hw/rtl/ddma_div.sv
`timescale 1ns / 1ps
module ddma_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [ddma_pkg::NUM_W-1:0]   num_i,
  input  logic        [ddma_pkg::W_W-1:0]     den_i,
  output logic                                done_o,
  output logic signed [ddma_pkg::NUM_W-1:0]   quot_o
);
  import ddma_pkg::*;

  logic              active_q, active_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [W_W:0]      rem_q, rem_d;
  logic [W_W-1:0]    den_q, den_d;
  logic [W_W:0]      rem_sh;
  logic [NUM_W-1:0]  q_adj;

  // restoring division, one quotient bit a cycle, on magnitudes
  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    neg_d    = neg_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    den_d    = den_q;
    rem_sh   = {rem_q[W_W-1:0], quo_q[NUM_W-1]};
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = DCNT_W'(NUM_W);
      neg_d    = num_i[NUM_W-1];
      quo_d    = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      rem_d    = '0;
      den_d    = den_i;
    end else if (active_q && (cnt_q != '0)) begin
      cnt_d = cnt_q - DCNT_W'(1);
      if (rem_sh >= {1'b0, den_q}) begin
        rem_d = rem_sh - {1'b0, den_q};
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  // floor for negative numerators: round magnitude up, then negate
  assign q_adj  = quo_q + NUM_W'(rem_q != '0);
  assign quot_o = neg_q ? $signed(-q_adj) : $signed(quo_q);
  assign done_o = active_q && (cnt_q == '0);
endmodule

>>> hw/rtl/ddma_ctrl.sv
`timescale 1ns / 1ps
module ddma_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ddma_pkg::status_t status_i,
  output ddma_pkg::cmd_t    cmd_o,
  output logic              in_ready_o
);
  import ddma_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (status_i.in_valid) state_d = ST_READ;
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: begin
        priority if (status_i.h_zero) state_d = ST_EMIT_D;
        else if (status_i.k_ge_w)     state_d = ST_DIV_LD;
        else if (status_i.k_ge_h)     state_d = ST_RD_H;
        else if (status_i.eor)        state_d = ST_FL_RD;
        else                          state_d = ST_FINISH;
      end
      ST_DIV_LD: state_d = ST_DIV;
      ST_DIV:    if (status_i.div_done) state_d = ST_EMIT_DIV;
      ST_RD_H:   state_d = ST_EMIT_H;
      ST_EMIT_D: if (status_i.out_free) state_d = ST_FINISH;
      ST_EMIT_DIV, ST_EMIT_H: begin
        if (status_i.out_free) state_d = status_i.eor ? ST_FL_RD : ST_FINISH;
      end
      ST_FL_RD:  state_d = ST_EMIT_FL;
      ST_EMIT_FL: begin
        if (status_i.out_free) state_d = status_i.m_zero ? ST_FINISH : ST_FL_RD;
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '{capture: 1'b0, rd_sel: RD_NONE, update: 1'b0, div_start: 1'b0,
                   emit: 1'b0, sel: SEL_D, emit_avg: 1'b0, emit_fin: 1'b0,
                   m_dec: 1'b0, finish: 1'b0};
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = status_i.in_valid;
      end
      ST_READ:   cmd_o.rd_sel = RD_FIRST;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_DIV_LD: cmd_o.div_start = 1'b1;
      ST_DIV:    ;
      ST_RD_H:   cmd_o.rd_sel = RD_H;
      ST_EMIT_D: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.sel      = SEL_D;
        cmd_o.emit_fin = status_i.eor;
      end
      ST_EMIT_DIV: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.sel      = SEL_DIV;
        cmd_o.emit_avg = 1'b1;
      end
      ST_EMIT_H: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.sel  = SEL_MEM;
      end
      ST_FL_RD:  cmd_o.rd_sel = RD_M;
      ST_EMIT_FL: begin
        cmd_o.emit     = status_i.out_free;
        cmd_o.sel      = SEL_MEM;
        cmd_o.emit_fin = status_i.m_zero;
        cmd_o.m_dec    = status_i.out_free;
      end
      ST_FINISH: cmd_o.finish = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

>>> hw/rtl/ddma_dpath.sv
`timescale 1ns / 1ps
module ddma_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ddma_pkg::cmd_t                    cmd_i,
  output ddma_pkg::status_t                 status_o,
  input  logic                              in_valid_i,
  input  logic [ddma_pkg::SAMPLE_W-1:0]     sample_i,
  input  logic                              eor_i,
  input  logic                              cfg_we_i,
  input  logic [ddma_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ddma_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ddma_pkg::OUT_W-1:0] filtered_o,
  output logic                              averaged_o,
  output logic                              final_res_o
);
  import ddma_pkg::*;

  logic [SAMPLE_W-1:0] base_q;
  logic [DL_W-1:0]     dly_cfg_q;
  logic [H_W-1:0]      hw_cfg_q;

  logic [DL_W-1:0] dl;
  logic [H_W-1:0]  h, h_m1;
  logic [W_W-1:0]  w;

  logic signed [S_W-1:0]   s_q, old;
  logic                    eor_q;
  logic signed [D_W-1:0]   d_q, d_new;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [IDX_W-1:0]        idx_q;
  logic [DLY_AW-1:0]       dly_pos_q;
  logic [WIN_AW-1:0]       win_pos_q, win_next;
  logic [H_W-1:0]          m_q;
  logic                    restart;

  logic signed [S_W-1:0] dmem [MAX_DELAY];
  logic signed [D_W-1:0] wmem [WIN_DEPTH];
  logic signed [S_W-1:0] drd_q;
  logic signed [D_W-1:0] wrd_q;
  logic [DLY_AW-1:0]     dly_raddr;
  logic [WIN_AW-1:0]     win_raddr;
  logic [W_W-1:0]        back_m;

  logic k_ge_dl, k_ge_h, k_ge_w;

  logic signed [NUM_W-1:0] num, quot;
  logic                    div_done;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_val_q;
  logic                    out_avg_q, out_fin_q;
  logic signed [OUT_W-1:0] out_sel_val;

  function automatic logic [WIN_AW-1:0] win_back(input logic [WIN_AW-1:0] pos,
                                                 input logic [W_W-1:0] m);
    logic [WIN_AW:0] t;
    t = {1'b0, pos} + (WIN_AW+1)'(WIN_DEPTH) - {1'b0, m};
    if (t >= (WIN_AW+1)'(WIN_DEPTH)) t = t - (WIN_AW+1)'(WIN_DEPTH);
    return t[WIN_AW-1:0];
  endfunction

  // oversized settings are clamped
  assign dl   = (dly_cfg_q > DL_W'(MAX_DELAY)) ? DL_W'(MAX_DELAY) : dly_cfg_q;
  assign h    = (hw_cfg_q > H_W'(MAX_HALF)) ? H_W'(MAX_HALF) : hw_cfg_q;
  assign h_m1 = h - H_W'(1);
  assign w    = {h, 1'b1};

  assign k_ge_dl = idx_q >= IDX_W'(dl);
  assign k_ge_h  = idx_q >= IDX_W'(h);
  assign k_ge_w  = idx_q >= IDX_W'(w);

  assign restart = cfg_we_i && (cfg_idx_i == REG_BASELINE || cfg_idx_i == REG_DELAY ||
                                cfg_idx_i == REG_HALF_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      dly_cfg_q <= DELAY_RESET;
      hw_cfg_q  <= HALF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASELINE:   base_q    <= cfg_wdata_i;
        REG_DELAY:      dly_cfg_q <= cfg_wdata_i[DL_W-1:0];
        REG_HALF_WIDTH: hw_cfg_q  <= cfg_wdata_i[H_W-1:0];
        default:        ;
      endcase
    end
  end

  // sample capture, baseline removed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eor_q <= 1'b0;
    end else if (cmd_i.capture) begin
      eor_q <= eor_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q <= $signed({1'b0, sample_i}) - $signed({1'b0, base_q});
    end
  end

  // store read addresses
  assign dly_raddr = dly_pos_q - dl[DLY_AW-1:0];
  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_FIRST: back_m = w;
      RD_H:     back_m = W_W'(h);
      RD_M:     back_m = W_W'(m_q);
      default:  back_m = '0;
    endcase
  end
  assign win_raddr = win_back(win_pos_q, back_m);

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_sel == RD_FIRST) drd_q <= dmem[dly_raddr];
    if (cmd_i.rd_sel != RD_NONE)  wrd_q <= wmem[win_raddr];
  end

  assign old   = ((dl != '0) && k_ge_dl) ? drd_q : '0;
  assign d_new = (dl == '0) ? D_W'(s_q) : D_W'(s_q) - D_W'(old);
  assign sum_d = sum_q - (k_ge_w ? SUM_W'(wrd_q) : '0) + SUM_W'(d_new);

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      dmem[dly_pos_q] <= s_q;
      wmem[win_pos_q] <= d_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      d_q <= d_new;
      m_q <= (idx_q < IDX_W'(h_m1)) ? idx_q[H_W-1:0] : h_m1;
    end else if (cmd_i.m_dec) begin
      m_q <= m_q - H_W'(1);
    end
  end

  assign win_next = (win_pos_q == WIN_AW'(WIN_DEPTH - 1)) ? '0 : win_pos_q + WIN_AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      idx_q     <= '0;
      dly_pos_q <= '0;
      win_pos_q <= '0;
    end else if (restart || (cmd_i.finish && eor_q)) begin
      sum_q     <= '0;
      idx_q     <= '0;
      dly_pos_q <= '0;
      win_pos_q <= '0;
    end else if (cmd_i.update) begin
      sum_q <= sum_d;
    end else if (cmd_i.finish) begin
      dly_pos_q <= dly_pos_q + DLY_AW'(1);
      win_pos_q <= win_next;
      if (idx_q != '1) idx_q <= idx_q + IDX_W'(1);
    end
  end

  assign num = NUM_W'(sum_q) <<< FRAC_W;

  ddma_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (w),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // output register
  always_comb begin
    unique case (cmd_i.sel)
      SEL_D:   out_sel_val = OUT_W'(d_q) <<< FRAC_W;
      SEL_DIV: out_sel_val = quot[OUT_W-1:0];
      SEL_MEM: out_sel_val = OUT_W'(wrd_q) <<< FRAC_W;
      default: out_sel_val = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_val_q <= out_sel_val;
      out_avg_q <= cmd_i.emit_avg;
      out_fin_q <= cmd_i.emit_fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_val_q;
  assign averaged_o  = out_avg_q;
  assign final_res_o = out_fin_q;

  assign status_o = '{in_valid: in_valid_i, h_zero: (h == '0), k_ge_h: k_ge_h,
                      k_ge_w: k_ge_w, eor: eor_q, m_zero: (m_q == '0),
                      div_done: div_done, out_free: (!out_valid_q || out_ready_i)};
endmodule
